FILE: rtl/fax_mh_run_length_encoder_core_defines.svh
// Assertion macros for the fax MH run length encoder.
`ifndef FAX_MH_RUN_LENGTH_ENCODER_CORE_DEFINES_SVH
`define FAX_MH_RUN_LENGTH_ENCODER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked on every clock, disabled in reset.
`define FMHE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every clock, reset included.
`define FMHE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FMHE_ASSERT(lbl, prop, msg)
`define FMHE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/fmhe_pkg.sv
// Shared types, constants and code tables for the fax MH encoder.
package fmhe_pkg;

  localparam int unsigned MAX_LINE_WIDTH = 2560;
  localparam int unsigned RTC_EXTRA_EOLS = 5;
  localparam int unsigned LINE_WIDTH_RESET = 1728;

  // ROM bases
  localparam logic [7:0] WHITE_TERM_BASE = 8'd0;
  localparam logic [7:0] BLACK_TERM_BASE = 8'd64;
  localparam logic [7:0] WHITE_MAKE_BASE = 8'd128;
  localparam logic [7:0] BLACK_MAKE_BASE = 8'd168;
  localparam logic [5:0] MAKE_LAST = 6'd39;

  localparam logic [12:0] EOL_CODE = 13'h0001;
  localparam logic [3:0]  EOL_LEN  = 4'd12;

  typedef enum logic [1:0] {
    OP_CODE = 2'd0,  // plain code word
    OP_EOL  = 2'd1,  // zero fill to alignment plus EOL
    OP_PAD  = 2'd2   // zero pad to byte, marks last byte of page
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [12:0] code;
    logic [3:0]  len;
  } op_t;

  // entry = {len[3:0], code[12:0]}
  localparam logic [16:0] CODE_ROM [208] = '{
    // white terminating 0..63
    {4'd8,13'h35},{4'd6,13'h07},{4'd4,13'h7},{4'd4,13'h8},
    {4'd4,13'hB},{4'd4,13'hC},{4'd4,13'hE},{4'd4,13'hF},
    {4'd5,13'h13},{4'd5,13'h14},{4'd5,13'h07},{4'd5,13'h08},
    {4'd6,13'h08},{4'd6,13'h03},{4'd6,13'h34},{4'd6,13'h35},
    {4'd6,13'h2A},{4'd6,13'h2B},{4'd7,13'h27},{4'd7,13'h0C},
    {4'd7,13'h08},{4'd7,13'h17},{4'd7,13'h03},{4'd7,13'h04},
    {4'd7,13'h28},{4'd7,13'h2B},{4'd7,13'h13},{4'd7,13'h24},
    {4'd7,13'h18},{4'd8,13'h02},{4'd8,13'h03},{4'd8,13'h1A},
    {4'd8,13'h1B},{4'd8,13'h12},{4'd8,13'h13},{4'd8,13'h14},
    {4'd8,13'h15},{4'd8,13'h16},{4'd8,13'h17},{4'd8,13'h28},
    {4'd8,13'h29},{4'd8,13'h2A},{4'd8,13'h2B},{4'd8,13'h2C},
    {4'd8,13'h2D},{4'd8,13'h04},{4'd8,13'h05},{4'd8,13'h0A},
    {4'd8,13'h0B},{4'd8,13'h52},{4'd8,13'h53},{4'd8,13'h54},
    {4'd8,13'h55},{4'd8,13'h24},{4'd8,13'h25},{4'd8,13'h58},
    {4'd8,13'h59},{4'd8,13'h5A},{4'd8,13'h5B},{4'd8,13'h4A},
    {4'd8,13'h4B},{4'd8,13'h32},{4'd8,13'h33},{4'd8,13'h34},
    // black terminating 0..63
    {4'd10,13'h37},{4'd3,13'h2},{4'd2,13'h3},{4'd2,13'h2},
    {4'd3,13'h3},{4'd4,13'h3},{4'd4,13'h2},{4'd5,13'h3},
    {4'd6,13'h5},{4'd6,13'h4},{4'd7,13'h4},{4'd7,13'h5},
    {4'd7,13'h7},{4'd8,13'h4},{4'd8,13'h7},{4'd9,13'h18},
    {4'd10,13'h17},{4'd10,13'h18},{4'd10,13'h08},{4'd11,13'h67},
    {4'd11,13'h68},{4'd11,13'h6C},{4'd11,13'h37},{4'd11,13'h28},
    {4'd11,13'h17},{4'd11,13'h18},{4'd12,13'hCA},{4'd12,13'hCB},
    {4'd12,13'hCC},{4'd12,13'hCD},{4'd12,13'h68},{4'd12,13'h69},
    {4'd12,13'h6A},{4'd12,13'h6B},{4'd12,13'hD2},{4'd12,13'hD3},
    {4'd12,13'hD4},{4'd12,13'hD5},{4'd12,13'hD6},{4'd12,13'hD7},
    {4'd12,13'h6C},{4'd12,13'h6D},{4'd12,13'hDA},{4'd12,13'hDB},
    {4'd12,13'h54},{4'd12,13'h55},{4'd12,13'h56},{4'd12,13'h57},
    {4'd12,13'h64},{4'd12,13'h65},{4'd12,13'h52},{4'd12,13'h53},
    {4'd12,13'h24},{4'd12,13'h37},{4'd12,13'h38},{4'd12,13'h27},
    {4'd12,13'h28},{4'd12,13'h58},{4'd12,13'h59},{4'd12,13'h2B},
    {4'd12,13'h2C},{4'd12,13'h5A},{4'd12,13'h66},{4'd12,13'h67},
    // white makeup 64..2560
    {4'd5,13'h1B},{4'd5,13'h12},{4'd6,13'h17},{4'd7,13'h37},
    {4'd8,13'h36},{4'd8,13'h37},{4'd8,13'h64},{4'd8,13'h65},
    {4'd8,13'h68},{4'd8,13'h67},{4'd9,13'hCC},{4'd9,13'hCD},
    {4'd9,13'hD2},{4'd9,13'hD3},{4'd9,13'hD4},{4'd9,13'hD5},
    {4'd9,13'hD6},{4'd9,13'hD7},{4'd9,13'hD8},{4'd9,13'hD9},
    {4'd9,13'hDA},{4'd9,13'hDB},{4'd9,13'h98},{4'd9,13'h99},
    {4'd9,13'h9A},{4'd6,13'h18},{4'd9,13'h9B},
    {4'd11,13'h08},{4'd11,13'h0C},{4'd11,13'h0D},{4'd12,13'h12},
    {4'd12,13'h13},{4'd12,13'h14},{4'd12,13'h15},{4'd12,13'h16},
    {4'd12,13'h17},{4'd12,13'h1C},{4'd12,13'h1D},{4'd12,13'h1E},
    {4'd12,13'h1F},
    // black makeup 64..2560
    {4'd10,13'h0F},{4'd12,13'hC8},{4'd12,13'hC9},{4'd12,13'h5B},
    {4'd12,13'h33},{4'd12,13'h34},{4'd12,13'h35},{4'd13,13'h6C},
    {4'd13,13'h6D},{4'd13,13'h4A},{4'd13,13'h4B},{4'd13,13'h4C},
    {4'd13,13'h4D},{4'd13,13'h72},{4'd13,13'h73},{4'd13,13'h74},
    {4'd13,13'h75},{4'd13,13'h76},{4'd13,13'h77},{4'd13,13'h52},
    {4'd13,13'h53},{4'd13,13'h54},{4'd13,13'h55},{4'd13,13'h5A},
    {4'd13,13'h5B},{4'd13,13'h64},{4'd13,13'h65},
    {4'd11,13'h08},{4'd11,13'h0C},{4'd11,13'h0D},{4'd12,13'h12},
    {4'd12,13'h13},{4'd12,13'h14},{4'd12,13'h15},{4'd12,13'h16},
    {4'd12,13'h17},{4'd12,13'h1C},{4'd12,13'h1D},{4'd12,13'h1E},
    {4'd12,13'h1F}
  };

  // Code word op from a ROM entry.
  function automatic op_t rom_op(input logic [7:0] idx);
    logic [16:0] e;
    op_t o;
    e = CODE_ROM[idx];
    o.kind = OP_CODE;
    o.len  = e[16:13];
    o.code = e[12:0];
    return o;
  endfunction

  // Makeup code op for a run of given colour and length (length >= 64).
  function automatic op_t makeup_op(input logic colour, input logic [11:0] len);
    logic [5:0] m;
    m = len[11:6] - 6'd1;
    if (m > MAKE_LAST) m = MAKE_LAST;
    return rom_op((colour ? BLACK_MAKE_BASE : WHITE_MAKE_BASE) + {2'b00, m});
  endfunction

  // Terminating code op for a run of given colour and length.
  function automatic op_t term_op(input logic colour, input logic [11:0] len);
    return rom_op((colour ? BLACK_TERM_BASE : WHITE_TERM_BASE) + {2'b00, len[5:0]});
  endfunction

endpackage

FILE: rtl/fax_mh_run_length_encoder_core.sv
// Top level of the fax Group 3 one-dimensional MH run length encoder.
// Takes one pixel per item and produces T.4 MH coded bytes, MSB first. A pixel
// that does not end a run or line is taken back to back, with no stall. An item
// that codes runs, EOLs or the page end becomes a short list of up to 12 code
// words (leading EOL, two codes per run, EOL, five RTC EOLs, pad). The bit
// packer takes them one per cycle while its buffer has room, and the input
// stalls until the last one is taken. The packer sends at most one byte per
// cycle and takes a code word only while its 32-bit buffer has room for it.
// Once that buffer fills, the output byte rate sets the pace. A page end item,
// which can carry about 20 bytes of code, then holds the input until its code
// words are all taken, also across output stalls. No clearing pass after reset.
`include "fax_mh_run_length_encoder_core_defines.svh"
module fax_mh_run_length_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_pixel_i,
  input  logic        in_end_of_page_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_data_byte_o,
  output logic        out_last_o
);

  localparam int unsigned NUM_SLOTS = 7 + fmhe_pkg::RTC_EXTRA_EOLS;
  localparam int unsigned PAD_SLOT  = NUM_SLOTS - 1;

  logic [11:0] line_width_q;
  logic        run_colour_q, run_colour_d;
  logic [11:0] run_count_q, run_count_d;
  logic [11:0] line_position_q, line_position_d;
  logic        page_started_q, page_started_d;

  fmhe_pkg::op_t        slot_q [NUM_SLOTS];
  fmhe_pkg::op_t        slot_d [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] mask_q, mask_d, new_mask;
  logic [NUM_SLOTS-1:0] sel, issue_mask;

  logic        in_acc;
  logic [11:0] w;
  logic        chg;
  logic        colour1;
  logic [11:0] count1, pos1;
  logic        close;
  fmhe_pkg::op_t sel_op, eol_op, rtc_op, pad_op;
  logic        op_ready;

  // Clamp the line width to the legal range
  always_comb begin
    w = line_width_q;
    if (w == '0) w = 12'd1;
    if (w > 12'(fmhe_pkg::MAX_LINE_WIDTH)) w = 12'(fmhe_pkg::MAX_LINE_WIDTH);
  end

  // Run and line tracking for the offered pixel
  always_comb begin
    chg     = in_pixel_i != run_colour_q;
    colour1 = chg ? in_pixel_i : run_colour_q;
    count1  = (chg ? 12'd0 : run_count_q) + 12'd1;
    pos1    = line_position_q + 12'd1;
    close   = pos1 >= w;
  end

  // Code word list for the item
  always_comb begin
    eol_op = '{kind: fmhe_pkg::OP_EOL, code: fmhe_pkg::EOL_CODE, len: fmhe_pkg::EOL_LEN};
    rtc_op = '{kind: fmhe_pkg::OP_CODE, code: fmhe_pkg::EOL_CODE, len: fmhe_pkg::EOL_LEN};
    pad_op = '{kind: fmhe_pkg::OP_PAD, code: '0, len: '0};
    for (int i = 0; i < NUM_SLOTS; i++) slot_d[i] = rtc_op;
    slot_d[0] = eol_op;
    slot_d[1] = fmhe_pkg::makeup_op(run_colour_q, run_count_q);
    slot_d[2] = fmhe_pkg::term_op(run_colour_q, run_count_q);
    slot_d[3] = fmhe_pkg::makeup_op(colour1, count1);
    slot_d[4] = fmhe_pkg::term_op(colour1, count1);
    slot_d[5] = eol_op;
    slot_d[PAD_SLOT] = pad_op;
    new_mask = '0;
    new_mask[0] = !page_started_q;
    new_mask[1] = chg && (run_count_q >= 12'd64);
    new_mask[2] = chg;
    new_mask[3] = (close || in_end_of_page_i) && (count1 >= 12'd64);
    new_mask[4] = close || in_end_of_page_i;
    new_mask[5] = close || in_end_of_page_i;
    for (int i = 6; i < NUM_SLOTS; i++) new_mask[i] = in_end_of_page_i;
  end

  // Oldest pending slot goes to the packer
  always_comb begin
    sel    = mask_q & (~mask_q + 1'b1);
    sel_op = slot_q[0];
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sel[i]) sel_op = slot_q[i];
    end
    issue_mask = op_ready ? sel : '0;
  end

  assign in_stall_o = (mask_q & ~issue_mask) != '0;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign mask_d     = in_acc ? new_mask : (mask_q & ~issue_mask);

  // Next run state
  always_comb begin
    run_colour_d    = colour1;
    run_count_d     = count1;
    line_position_d = pos1;
    page_started_d  = 1'b1;
    if (close) begin
      run_colour_d    = 1'b0;
      run_count_d     = '0;
      line_position_d = '0;
    end
    if (in_end_of_page_i) begin
      run_colour_d    = 1'b0;
      run_count_d     = '0;
      line_position_d = '0;
      page_started_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q    <= 12'(fmhe_pkg::LINE_WIDTH_RESET);
      run_colour_q    <= 1'b0;
      run_count_q     <= '0;
      line_position_q <= '0;
      page_started_q  <= 1'b0;
      mask_q          <= '0;
    end else begin
      if (cfg_we_i) line_width_q <= cfg_wdata_i;
      if (in_acc) begin
        run_colour_q    <= run_colour_d;
        run_count_q     <= run_count_d;
        line_position_q <= line_position_d;
        page_started_q  <= page_started_d;
      end
      mask_q <= mask_d;
    end
  end

  // Slot payload
  always_ff @(posedge clk_i) begin
    if (in_acc) slot_q <= slot_d;
  end

  fmhe_packer u_packer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_valid_i      (mask_q != '0),
    .op_i            (sel_op),
    .op_ready_o      (op_ready),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_data_byte_o (out_data_byte_o),
    .out_last_o      (out_last_o)
  );

  // Checks
  `FMHE_ASSERT(a_no_stall_when_empty, (mask_q == '0) |-> !in_stall_o, "stall with no pending code")
  `FMHE_ASSERT(a_eop_queues_pad, (in_acc && in_end_of_page_i) |=> mask_q[PAD_SLOT], "page end lost its pad")
  `FMHE_ASSERT_ALWAYS(a_fresh_page_clear, !page_started_q |-> ((run_count_q == '0) && (line_position_q == '0)), "run state left over at page start")

endmodule

FILE: rtl/fmhe_packer.sv
// Bit packer: appends code words MSB first and sends at most one byte per cycle while the output is not stalled.
module fmhe_packer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           op_valid_i,
  input  fmhe_pkg::op_t  op_i,
  output logic           op_ready_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_data_byte_o,
  output logic           out_last_o
);

  logic [31:0] buf_q, buf_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [5:0]  last_cnt_q, last_cnt_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_last_q, out_last_d;

  logic        drain;
  logic [5:0]  cnt_dr;
  logic [2:0]  fill;
  logic [4:0]  len_eff;
  logic [12:0] code_eff;
  logic        apply;

  // Effective length and code of the offered op
  always_comb begin
    fill = 3'd4 - cnt_q[2:0];
    case (op_i.kind)
      fmhe_pkg::OP_EOL: begin
        len_eff  = 5'({1'b0, fmhe_pkg::EOL_LEN}) + {2'b00, fill};
        code_eff = fmhe_pkg::EOL_CODE;
      end
      fmhe_pkg::OP_PAD: begin
        len_eff  = {2'b00, 3'd0 - cnt_q[2:0]};
        code_eff = '0;
      end
      default: begin
        len_eff  = {1'b0, op_i.len};
        code_eff = op_i.code;
      end
    endcase
  end

  // Drain one byte when the output register frees up
  assign drain  = (cnt_q >= 6'd8) && (!out_valid_q || !out_stall_i);
  assign cnt_dr = drain ? cnt_q - 6'd8 : cnt_q;

  // Take an op only if it fits and no earlier page end is still in flight
  assign op_ready_o = ({1'b0, cnt_dr} + {2'b00, len_eff} <= 7'd32) &&
                      ((op_i.kind != fmhe_pkg::OP_PAD) || (last_cnt_q == '0));
  assign apply = op_valid_i && op_ready_o;

  always_comb begin
    buf_d      = apply ? ((buf_q << len_eff) | {19'd0, code_eff}) : buf_q;
    cnt_d      = cnt_dr + (apply ? {1'b0, len_eff} : 6'd0);
    last_cnt_d = last_cnt_q;
    if (drain && (last_cnt_q != '0)) last_cnt_d = last_cnt_q - 6'd8;
    if (apply && (op_i.kind == fmhe_pkg::OP_PAD)) last_cnt_d = cnt_d;
    out_valid_d = drain ? 1'b1 : (out_valid_q && out_stall_i);
    out_byte_d  = drain ? 8'(buf_q >> (cnt_q - 6'd8)) : out_byte_q;
    out_last_d  = drain ? (last_cnt_q == 6'd8) : out_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      last_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      last_cnt_q  <= last_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    buf_q      <= buf_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_byte_o = out_byte_q;
  assign out_last_o      = out_last_q;

endmodule
